@@ hdl/cppt_pkg.sv @@
// ----------------------------------------------------------------------------
// cppt_pkg: shared types and constants for the C++ token recognizer
// Scan modes, result kinds, error codes and byte classification helpers.
// ----------------------------------------------------------------------------
package cppt_pkg;

  localparam int unsigned NMODE = 29;

  // One-hot scan modes
  typedef enum logic [NMODE-1:0] {
    M_IDLE   = 29'(1) << 0,
    M_START  = 29'(1) << 1,
    M_ID     = 29'(1) << 2,
    M_PL     = 29'(1) << 3,
    M_PSU    = 29'(1) << 4,
    M_PBU    = 29'(1) << 5,
    M_PR     = 29'(1) << 6,
    M_PU8    = 29'(1) << 7,
    M_PLR    = 29'(1) << 8,
    M_PUR16  = 29'(1) << 9,
    M_PUR32  = 29'(1) << 10,
    M_ZERO   = 29'(1) << 11,
    M_OCT    = 29'(1) << 12,
    M_DEC    = 29'(1) << 13,
    M_FRAC   = 29'(1) << 14,
    M_EXPS   = 29'(1) << 15,
    M_EXPF   = 29'(1) << 16,
    M_EXPD   = 29'(1) << 17,
    M_HEXF   = 29'(1) << 18,
    M_HEX    = 29'(1) << 19,
    M_SUF    = 29'(1) << 20,
    M_STR    = 29'(1) << 21,
    M_ESC    = 29'(1) << 22,
    M_ESCX   = 29'(1) << 23,
    M_ESCU4  = 29'(1) << 24,
    M_ESCU8  = 29'(1) << 25,
    M_ESCO   = 29'(1) << 26,
    M_RDEL   = 29'(1) << 27,
    M_RBODY  = 29'(1) << 28
  } mode_e;

  // Result kinds
  localparam logic [4:0] K_ID    = 5'd0;
  localparam logic [4:0] K_DEC   = 5'd1;
  localparam logic [4:0] K_OCT   = 5'd2;
  localparam logic [4:0] K_HEX   = 5'd3;
  localparam logic [4:0] K_FLOAT = 5'd4;
  localparam logic [4:0] K_STR0  = 5'd5;
  localparam logic [4:0] K_RAW0  = 5'd15;

  // Number classes kept in the class register while scanning a suffix
  localparam logic [3:0] C_DEC   = 4'd1;
  localparam logic [3:0] C_OCT   = 4'd2;
  localparam logic [3:0] C_HEX   = 4'd3;
  localparam logic [3:0] C_FLOAT = 4'd4;

  // Error codes
  localparam logic [3:0] E_NONE     = 4'd0;
  localparam logic [3:0] E_HEX_NODIG = 4'd1;
  localparam logic [3:0] E_OCT_DIG  = 4'd2;
  localparam logic [3:0] E_EXP_NODIG = 4'd3;
  localparam logic [3:0] E_FSUFFIX  = 4'd4;
  localparam logic [3:0] E_ISUFFIX  = 4'd5;
  localparam logic [3:0] E_ESC_X    = 4'd6;
  localparam logic [3:0] E_ESC_U4   = 4'd7;
  localparam logic [3:0] E_ESC_U8   = 4'd8;
  localparam logic [3:0] E_ESC_BAD  = 4'd9;
  localparam logic [3:0] E_UNTERM   = 4'd10;
  localparam logic [3:0] E_DEL_LONG = 4'd11;
  localparam logic [3:0] E_DEL_CHAR = 4'd12;
  localparam logic [3:0] E_RAW_OPEN = 4'd13;
  localparam logic [3:0] E_BAD_START = 4'd14;

  function automatic logic is_dig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_odig(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h37;
  endfunction

  function automatic logic is_xdig(input logic [7:0] b);
    return is_dig(b) || (b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46);
  endfunction

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) || b == 8'h5f;
  endfunction

  function automatic logic is_notdelim(input logic [7:0] b);
    return b == 8'h00 || b == 8'h20 || b == 8'h28 || b == 8'h29 || b == 8'h5c ||
           b == 8'h09 || b == 8'h0b || b == 8'h0c || b == 8'h0a || b == 8'h0d;
  endfunction

  function automatic logic [7:0] to_low(input logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) ? b + 8'd32 : b;
  endfunction

  // Integer or float suffix check on the last three suffix letters
  function automatic logic suffix_ok(input logic [3:0] cls, input logic [23:0] s,
                                     input logic [2:0] n);
    logic ok;
    ok = 1'b0;
    if (n > 3'd3) begin
      ok = 1'b0;
    end else if (cls == C_FLOAT) begin
      ok = (n == 3'd0) || (n == 3'd1 && (s == 24'h66 || s == 24'h6c));
    end else begin
      ok = (n == 3'd0) || s == 24'h75 || s == 24'h756c || s == 24'h756c6c ||
           s == 24'h6c || s == 24'h6c75 || s == 24'h6c6c || s == 24'h6c6c75;
    end
    return ok;
  endfunction

endpackage

@@ hdl/cppt_ram.sv @@
// ----------------------------------------------------------------------------
// cppt_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module cppt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ hdl/cpp_token_recognizer.sv @@
// ----------------------------------------------------------------------------
// cpp_token_recognizer: one-token C++ lexer for identifiers, numbers, strings
// Scans one byte per cycle and reports kind, error, length and whether the
// ending byte was consumed.
// ----------------------------------------------------------------------------
// Output: a result item is registered and appears on the master side in the
//   cycle after the input item that ends the token is accepted.
// Throughput: one input item per cycle; the slave side stalls only while a
//   result is held and the master side is not ready.
// Reset: asynchronous active-low; scan state goes idle, counters clear,
//   the delimiter RAM is not cleared (only entries of the current token are read).
module cpp_token_recognizer #(
  parameter int unsigned MAX_DELIM_LEN = 16,
  parameter int unsigned LENGTH_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] byte_req
  input  logic        s_axis_tuser_i,   // [0] start_req
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [4:0] kind, [8:5] error, [24:9] length, zero pad
  output logic        m_axis_tuser_o    // [0] byte_consumed
);

  localparam int unsigned DLW = $clog2(MAX_DELIM_LEN + 1);
  localparam int unsigned MPW = $clog2(MAX_DELIM_LEN + 3);
  localparam int unsigned AW  = (MAX_DELIM_LEN > 1) ? $clog2(MAX_DELIM_LEN) : 1;

  // scan state
  cppt_pkg::mode_e        mode_q, mode_d;
  logic [LENGTH_BITS-1:0] len_q, len_d;
  logic [3:0]             cls_q, cls_d;
  logic [3:0]             esc_q, esc_d;
  logic [23:0]            suf_q, suf_d;
  logic [2:0]             sufn_q, sufn_d;
  logic [DLW-1:0]         dlen_q, dlen_d;
  logic [MPW-1:0]         mp_q, mp_d;

  // result register
  logic        out_vld_q, out_vld_d;
  logic [4:0]  out_kind_q, out_kind_d;
  logic [3:0]  out_err_q, out_err_d;
  logic [15:0] out_len_q, out_len_d;
  logic        out_cons_q, out_cons_d;

  // delimiter RAM
  logic          ram_we;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  logic          acc;
  logic [7:0]    b;
  cppt_pkg::mode_e m;
  logic          res_v;
  logic [4:0]    res_kind;
  logic [3:0]    res_err;
  logic          res_cons;
  logic [7:0]    expect_c;
  logic [7:0]    quote_c;

  assign s_axis_tready_o = !out_vld_q || m_axis_tready_i;
  assign acc = s_axis_tvalid_i && s_axis_tready_o;
  assign b   = s_axis_tdata_i;

  // raw terminator: ')' then delimiter bytes then '"'
  always_comb begin
    if (mp_q == '0) begin
      expect_c = 8'h29;
    end else if ((DLW + 1)'(mp_q) <= (DLW + 1)'(dlen_q)) begin
      expect_c = ram_rdata;
    end else begin
      expect_c = 8'h22;
    end
  end

  assign quote_c = cls_q[0] ? 8'h27 : 8'h22;

  always_comb begin
    mode_d   = mode_q;
    len_d    = len_q;
    cls_d    = cls_q;
    esc_d    = esc_q;
    suf_d    = suf_q;
    sufn_d   = sufn_q;
    dlen_d   = dlen_q;
    mp_d     = mp_q;
    res_v    = 1'b0;
    res_kind = cppt_pkg::K_ID;
    res_err  = cppt_pkg::E_NONE;
    res_cons = 1'b0;
    ram_we   = 1'b0;
    m        = mode_q;

    if (acc) begin
      if (s_axis_tuser_i) begin
        len_d  = '0;
        cls_d  = '0;
        esc_d  = '0;
        suf_d  = '0;
        sufn_d = '0;
        dlen_d = '0;
        mp_d   = '0;
        m      = cppt_pkg::M_START;
      end

      // first fall-through: prefixes into identifiers, lone zero, escapes back to body
      unique case (m) inside
        cppt_pkg::M_PL, cppt_pkg::M_PSU, cppt_pkg::M_PBU: begin
          if (!(b == 8'h22 || b == 8'h27 || b == 8'h52 ||
                (m == cppt_pkg::M_PSU && b == 8'h38))) begin
            m = cppt_pkg::M_ID;
          end
        end
        cppt_pkg::M_PR: begin
          if (!(b == 8'h22 || b == 8'h4c || b == 8'h75 || b == 8'h55)) begin
            m = cppt_pkg::M_ID;
          end
        end
        cppt_pkg::M_PU8: begin
          if (!(b == 8'h22 || b == 8'h27)) m = cppt_pkg::M_ID;
        end
        cppt_pkg::M_PLR, cppt_pkg::M_PUR16, cppt_pkg::M_PUR32: begin
          if (b != 8'h22) m = cppt_pkg::M_ID;
        end
        cppt_pkg::M_ZERO: begin
          if (!(b == 8'h78 || b == 8'h58 || cppt_pkg::is_dig(b))) m = cppt_pkg::M_DEC;
        end
        cppt_pkg::M_ESCX: begin
          if (!cppt_pkg::is_xdig(b) && esc_q != 4'd0) m = cppt_pkg::M_STR;
        end
        cppt_pkg::M_ESCU4: begin
          if (!cppt_pkg::is_xdig(b) && esc_q == 4'd4) m = cppt_pkg::M_STR;
        end
        cppt_pkg::M_ESCU8: begin
          if (!cppt_pkg::is_xdig(b) && esc_q == 4'd8) m = cppt_pkg::M_STR;
        end
        cppt_pkg::M_ESCO: begin
          if (!cppt_pkg::is_odig(b)) m = cppt_pkg::M_STR;
        end
        default: ;
      endcase

      // second fall-through: end of digits moves into suffix scan
      unique case (m)
        cppt_pkg::M_DEC: begin
          if (!cppt_pkg::is_dig(b) && b != 8'h2e && b != 8'h65 && b != 8'h45) begin
            m = cppt_pkg::M_SUF; cls_d = cppt_pkg::C_DEC; suf_d = '0; sufn_d = '0;
          end
        end
        cppt_pkg::M_OCT: begin
          if (!cppt_pkg::is_dig(b)) begin
            m = cppt_pkg::M_SUF; cls_d = cppt_pkg::C_OCT; suf_d = '0; sufn_d = '0;
          end
        end
        cppt_pkg::M_FRAC: begin
          if (!cppt_pkg::is_dig(b) && b != 8'h65 && b != 8'h45) begin
            m = cppt_pkg::M_SUF; cls_d = cppt_pkg::C_FLOAT; suf_d = '0; sufn_d = '0;
          end
        end
        cppt_pkg::M_EXPD: begin
          if (!cppt_pkg::is_dig(b)) begin
            m = cppt_pkg::M_SUF; cls_d = cppt_pkg::C_FLOAT; suf_d = '0; sufn_d = '0;
          end
        end
        cppt_pkg::M_HEX: begin
          if (!cppt_pkg::is_xdig(b)) begin
            m = cppt_pkg::M_SUF; cls_d = cppt_pkg::C_HEX; suf_d = '0; sufn_d = '0;
          end
        end
        default: ;
      endcase

      mode_d = m;

      // main per-byte decision; "take" bumps the saturating length
      unique case (m)
        cppt_pkg::M_START: begin
          mode_d = cppt_pkg::M_ID;
          if (b == 8'h30) mode_d = cppt_pkg::M_ZERO;
          else if (cppt_pkg::is_dig(b)) mode_d = cppt_pkg::M_DEC;
          else if (b == 8'h2e) mode_d = cppt_pkg::M_FRAC;
          else if (b == 8'h22) begin mode_d = cppt_pkg::M_STR; cls_d = 4'd0; end
          else if (b == 8'h27) begin mode_d = cppt_pkg::M_STR; cls_d = 4'd1; end
          else if (b == 8'h4c) mode_d = cppt_pkg::M_PL;
          else if (b == 8'h75) mode_d = cppt_pkg::M_PSU;
          else if (b == 8'h55) mode_d = cppt_pkg::M_PBU;
          else if (b == 8'h52) mode_d = cppt_pkg::M_PR;
          else if (!cppt_pkg::is_alpha(b)) begin
            res_v = 1'b1; res_err = cppt_pkg::E_BAD_START;
          end
        end
        cppt_pkg::M_ID: begin
          if (!(cppt_pkg::is_alpha(b) || cppt_pkg::is_dig(b))) begin
            res_v = 1'b1; res_kind = cppt_pkg::K_ID;
          end
        end
        cppt_pkg::M_PL, cppt_pkg::M_PSU, cppt_pkg::M_PBU: begin
          if (b == 8'h22 || b == 8'h27) begin
            mode_d = cppt_pkg::M_STR;
            cls_d  = (m == cppt_pkg::M_PL) ? 4'd2 : (m == cppt_pkg::M_PSU) ? 4'd4 : 4'd6;
            cls_d[0] = (b == 8'h27);
          end else if (b == 8'h52) begin
            mode_d = (m == cppt_pkg::M_PL) ? cppt_pkg::M_PLR :
                     (m == cppt_pkg::M_PSU) ? cppt_pkg::M_PUR16 : cppt_pkg::M_PUR32;
          end else begin
            mode_d = cppt_pkg::M_PU8;
          end
        end
        cppt_pkg::M_PR: begin
          if (b == 8'h22) begin
            mode_d = cppt_pkg::M_RDEL; cls_d = 4'd0; dlen_d = '0;
          end else if (b == 8'h4c) mode_d = cppt_pkg::M_PLR;
          else if (b == 8'h75) mode_d = cppt_pkg::M_PUR16;
          else mode_d = cppt_pkg::M_PUR32;
        end
        cppt_pkg::M_PU8: begin
          mode_d = cppt_pkg::M_STR;
          cls_d  = (b == 8'h27) ? 4'd9 : 4'd8;
        end
        cppt_pkg::M_PLR, cppt_pkg::M_PUR16, cppt_pkg::M_PUR32: begin
          mode_d = cppt_pkg::M_RDEL;
          dlen_d = '0;
          cls_d  = (m == cppt_pkg::M_PLR) ? 4'd1 : (m == cppt_pkg::M_PUR16) ? 4'd2 : 4'd3;
        end
        cppt_pkg::M_ZERO: begin
          if (b == 8'h78 || b == 8'h58) mode_d = cppt_pkg::M_HEXF;
          else if (cppt_pkg::is_odig(b)) mode_d = cppt_pkg::M_OCT;
          else begin res_v = 1'b1; res_err = cppt_pkg::E_OCT_DIG; end
        end
        cppt_pkg::M_OCT: begin
          if (!cppt_pkg::is_odig(b)) begin res_v = 1'b1; res_err = cppt_pkg::E_OCT_DIG; end
        end
        cppt_pkg::M_DEC: begin
          if (b == 8'h2e) mode_d = cppt_pkg::M_FRAC;
          else if (b == 8'h65 || b == 8'h45) mode_d = cppt_pkg::M_EXPS;
        end
        cppt_pkg::M_FRAC: begin
          if (b == 8'h65 || b == 8'h45) mode_d = cppt_pkg::M_EXPS;
        end
        cppt_pkg::M_EXPS: begin
          if (b == 8'h2b || b == 8'h2d) mode_d = cppt_pkg::M_EXPF;
          else if (cppt_pkg::is_dig(b)) mode_d = cppt_pkg::M_EXPD;
          else begin res_v = 1'b1; res_err = cppt_pkg::E_EXP_NODIG; end
        end
        cppt_pkg::M_EXPF: begin
          if (cppt_pkg::is_dig(b)) mode_d = cppt_pkg::M_EXPD;
          else begin res_v = 1'b1; res_err = cppt_pkg::E_EXP_NODIG; end
        end
        cppt_pkg::M_EXPD: ;
        cppt_pkg::M_HEXF: begin
          if (cppt_pkg::is_xdig(b)) mode_d = cppt_pkg::M_HEX;
          else begin res_v = 1'b1; res_err = cppt_pkg::E_HEX_NODIG; end
        end
        cppt_pkg::M_HEX: ;
        cppt_pkg::M_SUF: begin
          if (b == 8'h66 || b == 8'h46 || b == 8'h6c || b == 8'h4c ||
              b == 8'h75 || b == 8'h55) begin
            suf_d = {suf_d[15:0], cppt_pkg::to_low(b)};
            if (sufn_d != 3'd7) sufn_d = sufn_d + 3'd1;
          end else begin
            res_v = 1'b1;
            if (cppt_pkg::suffix_ok(cls_d, suf_d, sufn_d)) res_kind = {1'b0, cls_d};
            else res_err = (cls_d == cppt_pkg::C_FLOAT) ? cppt_pkg::E_FSUFFIX
                                                         : cppt_pkg::E_ISUFFIX;
          end
        end
        cppt_pkg::M_STR: begin
          if (b == quote_c) begin
            res_v = 1'b1; res_cons = 1'b1; res_kind = cppt_pkg::K_STR0 + {1'b0, cls_d};
          end else if (b == 8'h5c) mode_d = cppt_pkg::M_ESC;
          else if (b == 8'h00) begin res_v = 1'b1; res_err = cppt_pkg::E_UNTERM; end
        end
        cppt_pkg::M_ESC: begin
          esc_d = '0;
          if (b == 8'h61 || b == 8'h62 || b == 8'h66 || b == 8'h6e || b == 8'h72 ||
              b == 8'h74 || b == 8'h76 || b == 8'h5c || b == 8'h27 || b == 8'h22 ||
              b == 8'h3f) mode_d = cppt_pkg::M_STR;
          else if (b == 8'h78) mode_d = cppt_pkg::M_ESCX;
          else if (b == 8'h75) mode_d = cppt_pkg::M_ESCU4;
          else if (b == 8'h55) mode_d = cppt_pkg::M_ESCU8;
          else if (cppt_pkg::is_odig(b)) mode_d = cppt_pkg::M_ESCO;
          else begin res_v = 1'b1; res_err = cppt_pkg::E_ESC_BAD; end
        end
        cppt_pkg::M_ESCX, cppt_pkg::M_ESCU4, cppt_pkg::M_ESCU8: begin
          if (cppt_pkg::is_xdig(b)) begin
            if (esc_q != 4'd15) esc_d = esc_q + 4'd1;
          end else begin
            res_v   = 1'b1;
            res_err = (m == cppt_pkg::M_ESCX) ? cppt_pkg::E_ESC_X :
                      (m == cppt_pkg::M_ESCU4) ? cppt_pkg::E_ESC_U4 : cppt_pkg::E_ESC_U8;
          end
        end
        cppt_pkg::M_ESCO: ;
        cppt_pkg::M_RDEL: begin
          if (!cppt_pkg::is_notdelim(b)) begin
            if (dlen_q == DLW'(MAX_DELIM_LEN)) begin
              res_v = 1'b1; res_err = cppt_pkg::E_DEL_LONG;
            end else begin
              ram_we = 1'b1;
              dlen_d = dlen_q + DLW'(1);
            end
          end else if (b == 8'h28) begin
            mp_d = '0; mode_d = cppt_pkg::M_RBODY;
          end else begin
            res_v = 1'b1; res_err = cppt_pkg::E_DEL_CHAR;
          end
        end
        cppt_pkg::M_RBODY: begin
          if (b == 8'h00) begin
            res_v = 1'b1; res_err = cppt_pkg::E_RAW_OPEN;
          end else if (b == expect_c) begin
            mp_d = mp_q + MPW'(1);
            if ((MPW + 1)'(mp_d) >= (MPW + 1)'(dlen_q) + (MPW + 1)'(2)) begin
              res_v = 1'b1; res_cons = 1'b1; res_kind = cppt_pkg::K_RAW0 + {1'b0, cls_d};
            end
          end else begin
            mp_d = (b == 8'h29) ? MPW'(1) : '0;
          end
        end
        cppt_pkg::M_IDLE: ;
        default: mode_d = cppt_pkg::M_IDLE;
      endcase

      // length: a finish takes only when consuming, otherwise every live byte takes
      if ((m != cppt_pkg::M_IDLE) && (!res_v || res_cons)) begin
        if (len_d != '1) len_d = len_d + LENGTH_BITS'(1);
      end
      if (res_v) begin
        mode_d = cppt_pkg::M_IDLE;
        if (res_err != cppt_pkg::E_NONE) res_kind = cppt_pkg::K_ID;
      end
    end
  end

  // prefetch the next expected delimiter byte
  always_comb begin
    ram_raddr = '0;
    if (mp_d != '0 && (MPW + 1)'(mp_d) <= (MPW + 1)'(MAX_DELIM_LEN)) begin
      ram_raddr = AW'(mp_d - MPW'(1));
    end
  end

  cppt_ram #(
    .WIDTH (8),
    .DEPTH (MAX_DELIM_LEN),
    .AW    (AW)
  ) u_delim_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(dlen_q)),
    .wdata_i (b),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // result register
  always_comb begin
    out_vld_d  = out_vld_q;
    out_kind_d = out_kind_q;
    out_err_d  = out_err_q;
    out_len_d  = out_len_q;
    out_cons_d = out_cons_q;
    if (m_axis_tready_i) out_vld_d = 1'b0;
    if (acc && res_v) begin
      out_vld_d  = 1'b1;
      out_kind_d = res_kind;
      out_err_d  = res_err;
      out_len_d  = 16'(len_d);
      out_cons_d = res_cons;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= cppt_pkg::M_IDLE;
      len_q     <= '0;
      cls_q     <= '0;
      esc_q     <= '0;
      suf_q     <= '0;
      sufn_q    <= '0;
      dlen_q    <= '0;
      mp_q      <= '0;
      out_vld_q <= 1'b0;
    end else begin
      mode_q    <= mode_d;
      len_q     <= len_d;
      cls_q     <= cls_d;
      esc_q     <= esc_d;
      suf_q     <= suf_d;
      sufn_q    <= sufn_d;
      dlen_q    <= dlen_d;
      mp_q      <= mp_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_kind_q <= out_kind_d;
    out_err_q  <= out_err_d;
    out_len_q  <= out_len_d;
    out_cons_q <= out_cons_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {7'd0, out_len_q, out_err_q, out_kind_q};
  assign m_axis_tuser_o  = out_cons_q;

  // an error result carries no kind and never keeps the failing byte
  a_err_no_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_err_q != cppt_pkg::E_NONE |-> out_kind_q == cppt_pkg::K_ID && !out_cons_q)
    else $error("error result with kind or consumed byte");

  // match position never passes the end of the terminator
  a_mp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == cppt_pkg::M_RBODY |-> (DLW + 1)'(mp_q) <= (DLW + 1)'(dlen_q) + (DLW + 1)'(1))
    else $error("raw match position out of range");

  // length only grows within a token
  a_len_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && !s_axis_tuser_i |=> len_q >= $past(len_q))
    else $error("token length shrank");

  // delimiter length stays within its store
  a_dlen_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (DLW + 1)'(dlen_q) <= (DLW + 1)'(MAX_DELIM_LEN))
    else $error("delimiter length overflow");

endmodule

@@ tb/tb_cpp_token_recognizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cpp_token_recognizer: self-checking bench for the C++ token recognizer
// Feeds byte items that form whole and broken tokens, predicts each token
// result in a behavioral scanner and checks the result stream in order,
// with random gaps on both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_cpp_token_recognizer;

  localparam int unsigned MAXD = 16;
  localparam int unsigned LIMIT_CYCLES = 100000;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } src_item_t;

  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  err;
    logic [15:0] len;
    logic        took;
  } token_res_t;

  // Scanner state
  typedef enum int {
    S_IDLE, S_START, S_ID, S_PL, S_PSU, S_PBU, S_PR, S_PU8, S_PLR, S_PUR16,
    S_PUR32, S_ZERO, S_OCT, S_DEC, S_FRAC, S_EXPS, S_EXPF, S_EXPD, S_HEXF,
    S_HEX, S_SUF, S_STR, S_ESC, S_ESCX, S_ESCU4, S_ESCU8, S_ESCO, S_RDEL,
    S_RBODY
  } scan_e;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic m_tuser;

  cpp_token_recognizer u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tuser_o(m_tuser)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  src_item_t  pending_bytes[$];
  token_res_t expected_tokens[$];
  int mismatches = 0;
  int cycles = 0;
  int stall_hold = 0;     // long output stall, counted down by its own process
  bit stall_req = 1'b0;

  // Predictor state
  scan_e       sc_mode = S_IDLE;
  logic [15:0] sc_len;
  logic [3:0]  sc_cls;
  logic [3:0]  sc_escn;
  logic [23:0] sc_suf;
  logic [2:0]  sc_sufn;
  logic [7:0]  sc_delim[MAXD];
  logic [4:0]  sc_dlen;
  logic [4:0]  sc_match;

  function automatic bit alnum(logic [7:0] b);
    return cppt_pkg::is_alpha(b) || cppt_pkg::is_dig(b);
  endfunction

  function automatic void take_byte();
    if (sc_len != 16'hFFFF) sc_len++;
  endfunction

  function automatic void emit(logic [4:0] kind, logic [3:0] err, bit took);
    token_res_t r;
    if (took) take_byte();
    r.kind = (err != cppt_pkg::E_NONE) ? cppt_pkg::K_ID : kind;
    r.err  = err;
    r.len  = sc_len;
    r.took = took;
    expected_tokens.push_back(r);
    sc_mode = S_IDLE;
  endfunction

  function automatic void go(scan_e m);
    sc_mode = m;
    take_byte();
  endfunction

  function automatic void to_suffix(logic [3:0] cls);
    sc_cls = cls; sc_suf = '0; sc_sufn = '0; sc_mode = S_SUF;
  endfunction

  function automatic bit suffix_good();
    if (sc_sufn > 3) return 1'b0;
    if (sc_cls == cppt_pkg::C_FLOAT)
      return sc_sufn == 0 || (sc_sufn == 1 && (sc_suf == "f" || sc_suf == "l"));
    return sc_sufn == 0 || sc_suf == "u" || sc_suf == "ul" || sc_suf == "ull" ||
           sc_suf == "l" || sc_suf == "lu" || sc_suf == "ll" || sc_suf == "llu";
  endfunction

  // Advance the scanner by one byte; may push one expected token.
  function automatic void scan_byte(logic [7:0] b, bit first);
    logic [7:0] want;
    int q;
    bit again;
    if (first) begin
      sc_len = '0; sc_cls = '0; sc_escn = '0; sc_suf = '0; sc_sufn = '0;
      sc_dlen = '0; sc_match = '0; sc_mode = S_START;
    end else if (sc_mode == S_IDLE) begin
      return;
    end
    do begin
      again = 1'b0;
      case (sc_mode)
        S_START: begin
          if (b == "0") go(S_ZERO);
          else if (cppt_pkg::is_dig(b)) go(S_DEC);
          else if (b == ".") go(S_FRAC);
          else if (b == "\"" || b == "'") begin sc_cls = 4'(b == "'"); go(S_STR); end
          else if (b == "L") go(S_PL);
          else if (b == "u") go(S_PSU);
          else if (b == "U") go(S_PBU);
          else if (b == "R") go(S_PR);
          else if (cppt_pkg::is_alpha(b)) go(S_ID);
          else emit(cppt_pkg::K_ID, cppt_pkg::E_BAD_START, 0);
        end
        S_ID: if (alnum(b)) take_byte(); else emit(cppt_pkg::K_ID, cppt_pkg::E_NONE, 0);
        S_PL, S_PSU, S_PBU: begin
          q = (sc_mode == S_PL) ? 1 : (sc_mode == S_PSU) ? 2 : 3;
          if (b == "\"" || b == "'") begin
            sc_cls = 4'(2 * q + int'(b == "'")); go(S_STR);
          end
          else if (b == "R") go(q == 1 ? S_PLR : q == 2 ? S_PUR16 : S_PUR32);
          else if (q == 2 && b == "8") go(S_PU8);
          else begin sc_mode = S_ID; again = 1; end
        end
        S_PR: begin
          if (b == "\"") begin sc_cls = 4'd0; sc_dlen = 5'd0; go(S_RDEL); end
          else if (b == "L") go(S_PLR);
          else if (b == "u") go(S_PUR16);
          else if (b == "U") go(S_PUR32);
          else begin sc_mode = S_ID; again = 1; end
        end
        S_PU8: begin
          if (b == "\"") begin sc_cls = 4'd8; go(S_STR); end
          else if (b == "'") begin sc_cls = 4'd9; go(S_STR); end
          else begin sc_mode = S_ID; again = 1; end
        end
        S_PLR, S_PUR16, S_PUR32: begin
          if (b == "\"") begin
            sc_cls = (sc_mode == S_PLR) ? 4'd1 : (sc_mode == S_PUR16) ? 4'd2 : 4'd3;
            sc_dlen = 5'd0; go(S_RDEL);
          end else begin sc_mode = S_ID; again = 1; end
        end
        S_ZERO: begin
          if (b == "x" || b == "X") go(S_HEXF);
          else if (cppt_pkg::is_odig(b)) go(S_OCT);
          else if (cppt_pkg::is_dig(b)) emit(cppt_pkg::K_ID, cppt_pkg::E_OCT_DIG, 0);
          else begin sc_mode = S_DEC; again = 1; end
        end
        S_OCT: begin
          if (cppt_pkg::is_odig(b)) take_byte();
          else if (cppt_pkg::is_dig(b)) emit(cppt_pkg::K_ID, cppt_pkg::E_OCT_DIG, 0);
          else begin to_suffix(cppt_pkg::C_OCT); again = 1; end
        end
        S_DEC: begin
          if (cppt_pkg::is_dig(b)) take_byte();
          else if (b == ".") go(S_FRAC);
          else if (b == "e" || b == "E") go(S_EXPS);
          else begin to_suffix(cppt_pkg::C_DEC); again = 1; end
        end
        S_FRAC: begin
          if (cppt_pkg::is_dig(b)) take_byte();
          else if (b == "e" || b == "E") go(S_EXPS);
          else begin to_suffix(cppt_pkg::C_FLOAT); again = 1; end
        end
        S_EXPS: begin
          if (b == "+" || b == "-") go(S_EXPF);
          else if (cppt_pkg::is_dig(b)) go(S_EXPD);
          else emit(cppt_pkg::K_ID, cppt_pkg::E_EXP_NODIG, 0);
        end
        S_EXPF: begin
          if (cppt_pkg::is_dig(b)) go(S_EXPD);
          else emit(cppt_pkg::K_ID, cppt_pkg::E_EXP_NODIG, 0);
        end
        S_EXPD: begin
          if (cppt_pkg::is_dig(b)) take_byte();
          else begin to_suffix(cppt_pkg::C_FLOAT); again = 1; end
        end
        S_HEXF: begin
          if (cppt_pkg::is_xdig(b)) go(S_HEX);
          else emit(cppt_pkg::K_ID, cppt_pkg::E_HEX_NODIG, 0);
        end
        S_HEX: begin
          if (cppt_pkg::is_xdig(b)) take_byte();
          else begin to_suffix(cppt_pkg::C_HEX); again = 1; end
        end
        S_SUF: begin
          if (b == "f" || b == "F" || b == "l" || b == "L" || b == "u" || b == "U") begin
            sc_suf = {sc_suf[15:0], cppt_pkg::to_low(b)};
            if (sc_sufn < 7) sc_sufn++;
            take_byte();
          end else if (suffix_good()) emit({1'b0, sc_cls}, cppt_pkg::E_NONE, 0);
          else emit(cppt_pkg::K_ID, (sc_cls == cppt_pkg::C_FLOAT) ? cppt_pkg::E_FSUFFIX
                                                                 : cppt_pkg::E_ISUFFIX, 0);
        end
        S_STR: begin
          want = sc_cls[0] ? "'" : "\"";
          if (b == want) emit(cppt_pkg::K_STR0 + {1'b0, sc_cls}, cppt_pkg::E_NONE, 1);
          else if (b == "\\") go(S_ESC);
          else if (b == 8'h00) emit(cppt_pkg::K_ID, cppt_pkg::E_UNTERM, 0);
          else take_byte();
        end
        S_ESC: begin
          sc_escn = 4'd0;
          if (b == "a" || b == "b" || b == "f" || b == "n" || b == "r" || b == "t" ||
              b == "v" || b == "\\" || b == "'" || b == "\"" || b == "?") go(S_STR);
          else if (b == "x") go(S_ESCX);
          else if (b == "u") go(S_ESCU4);
          else if (b == "U") go(S_ESCU8);
          else if (cppt_pkg::is_odig(b)) go(S_ESCO);
          else emit(cppt_pkg::K_ID, cppt_pkg::E_ESC_BAD, 0);
        end
        S_ESCX, S_ESCU4, S_ESCU8: begin
          if (cppt_pkg::is_xdig(b)) begin
            if (sc_escn < 15) sc_escn++;
            take_byte();
          end else if (sc_mode == S_ESCX && sc_escn == 0)
            emit(cppt_pkg::K_ID, cppt_pkg::E_ESC_X, 0);
          else if (sc_mode == S_ESCU4 && sc_escn != 4)
            emit(cppt_pkg::K_ID, cppt_pkg::E_ESC_U4, 0);
          else if (sc_mode == S_ESCU8 && sc_escn != 8)
            emit(cppt_pkg::K_ID, cppt_pkg::E_ESC_U8, 0);
          else begin sc_mode = S_STR; again = 1; end
        end
        S_ESCO: begin
          if (cppt_pkg::is_odig(b)) take_byte();
          else begin sc_mode = S_STR; again = 1; end
        end
        S_RDEL: begin
          if (!cppt_pkg::is_notdelim(b)) begin
            if (sc_dlen >= MAXD) emit(cppt_pkg::K_ID, cppt_pkg::E_DEL_LONG, 0);
            else begin sc_delim[sc_dlen] = b; sc_dlen++; take_byte(); end
          end else if (b == "(") begin sc_match = 5'd0; go(S_RBODY); end
          else emit(cppt_pkg::K_ID, cppt_pkg::E_DEL_CHAR, 0);
        end
        S_RBODY: begin
          if (b == 8'h00) emit(cppt_pkg::K_ID, cppt_pkg::E_RAW_OPEN, 0);
          else begin
            if (sc_match == 0) want = ")";
            else if (sc_match <= sc_dlen) want = sc_delim[sc_match - 1];
            else want = "\"";
            if (b == want) begin
              sc_match++;
              if (sc_match >= sc_dlen + 2) begin
                emit(cppt_pkg::K_RAW0 + {1'b0, sc_cls}, cppt_pkg::E_NONE, 1);
                return;
              end
            end else sc_match = (b == ")") ? 5'd1 : 5'd0;
            take_byte();
          end
        end
        default: sc_mode = S_IDLE;
      endcase
    end while (again);
  endfunction

  // ---- stimulus building --------------------------------------------------
  task automatic put_str(string s);
    for (int i = 0; i < s.len(); i++)
      pending_bytes.push_back('{ch: s[i], first: (i == 0)});
  endtask

  function automatic string pick(string pool);
    int k;
    k = $urandom_range(pool.len() - 1);
    return pool.substr(k, k);
  endfunction

  // Build one random token followed by a terminating byte.
  function automatic string rand_token();
    string s, d, pre;
    int n;
    case ($urandom_range(11))
      0: begin s = {pick("abzAZ_LuURx")}; n = $urandom_range(6);
         repeat (n) s = {s, pick("az09_QLR8")}; end
      1: begin s = {pick("123456789")};
         repeat ($urandom_range(5)) s = {s, pick("0123456789")}; end
      2: begin s = "0"; repeat ($urandom_range(4)) s = {s, pick("01234567789")}; end
      3: begin s = {"0", pick("xX")}; repeat ($urandom_range(4)) s = {s, pick("09afAFg")}; end
      4: begin s = {pick("0123.")}; repeat ($urandom_range(3)) s = {s, pick("0129.")};
         if ($urandom_range(1)) begin s = {s, pick("eE")};
           if ($urandom_range(1)) s = {s, pick("+-")};
           repeat ($urandom_range(3)) s = {s, pick("0189")}; end end
      5: begin s = {pick("0179")}; if ($urandom_range(1)) s = "0x1F";
         repeat ($urandom_range(1, 4)) s = {s, pick("uUlLfF")}; end
      6, 7: begin
        pre = (($urandom_range(1)) ? "" : ((($urandom_range(3)) == 0) ? "L" :
              (($urandom_range(2)) == 0) ? "u8" : pick("uU")));
        s = {pre, ($urandom_range(1) ? "\"" : "'")};
        repeat ($urandom_range(6)) begin
          case ($urandom_range(7))
            0: s = {s, "\\", pick("abfnrtv\\'\"?q")};
            1: begin s = {s, "\\x"}; repeat ($urandom_range(3)) s = {s, pick("0aF")}; end
            2: begin s = {s, "\\u"}; repeat ($urandom_range(3, 5)) s = {s, pick("09ab")}; end
            3: begin s = {s, "\\U"}; repeat ($urandom_range(7, 9)) s = {s, pick("19cD")}; end
            4: s = {s, "\\", pick("0127"), pick("089")};
            default: s = {s, pick("aZ 9(#")};
          endcase
        end
        s = {s, pick("\"'\"'z")};
      end
      8, 9, 10: begin
        pre = $urandom_range(1) ? "R" : {pick("LuU"), "R"};
        n = ($urandom_range(7) == 0) ? $urandom_range(15, 17) : $urandom_range(3);
        d = "";
        repeat (n) d = {d, pick("ab_\"Z9")};
        if ($urandom_range(9) == 0) d = {d, pick(" \\)\t")};
        s = {pre, "\"", d, "("};
        repeat ($urandom_range(5)) s = {s, pick("x)\"a)")};
        if ($urandom_range(4) != 0) s = {s, ")", d, "\""};
      end
      default: begin s = {pick("!#+ ~"), "a"}; end
    endcase
    s = {s, pick(" ;+,)")};
    return s;
  endfunction

  // ---- driver -------------------------------------------------------------
  int gap_left = 0;
  src_item_t cur;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) begin
        scan_byte(s_tdata, s_tuser);
        if (pending_bytes.size() != 0 && gap_left == 0 && rand_gap() == 0) begin
          cur = pending_bytes.pop_front();
          s_tdata <= cur.ch; s_tuser <= cur.first;
        end else begin
          s_tvalid <= 1'b0;
          gap_left <= rand_gap();
        end
      end else if (!s_tvalid) begin
        if (gap_left > 0) gap_left <= gap_left - 1;
        else if (pending_bytes.size() != 0) begin
          cur = pending_bytes.pop_front();
          s_tvalid <= 1'b1; s_tdata <= cur.ch; s_tuser <= cur.first;
        end
      end
    end
  end

  // ---- long output stall --------------------------------------------------
  always @(posedge clk_i) begin
    if (stall_req && stall_hold == 0) stall_hold <= 300;
    else if (stall_hold > 1) stall_hold <= stall_hold - 1;
  end

  // ---- monitor ------------------------------------------------------------
  token_res_t got, exp_r;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycles <= cycles + 1;
      if (m_tvalid && m_tready) begin
        got = '{kind: m_tdata[4:0], err: m_tdata[8:5], len: m_tdata[24:9], took: m_tuser};
        if (expected_tokens.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected token result kind=%0d err=%0d len=%0d took=%0b",
                     got.kind, got.err, got.len, got.took);
        end else begin
          exp_r = expected_tokens.pop_front();
          if (got !== exp_r || m_tdata[31:25] !== '0) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"token mismatch exp kind=%0d err=%0d len=%0d took=%0b, ",
                        "got kind=%0d err=%0d len=%0d took=%0b"},
                       exp_r.kind, exp_r.err, exp_r.len, exp_r.took,
                       got.kind, got.err, got.len, got.took);
          end
        end
      end
      if (stall_hold > 1) m_tready <= 1'b0;
      else if ($urandom_range(99) < 15) m_tready <= 1'b0;
      else if ($urandom_range(99) < 3 && !m_tready) m_tready <= 1'b0;
      else m_tready <= 1'b1;
    end
  end

  // ---- sequence -----------------------------------------------------------
  initial begin
    int total_n;
    // directed: every token family and each error path
    put_str("abc_9 "); put_str("123;"); put_str("0755u "); put_str("0x1Fllu,");
    put_str("0x;"); put_str("09 "); put_str("1.5e+3f "); put_str("2e;");
    put_str("1.0q "); put_str("3.5lf "); put_str("10ulz "); put_str("7ULLU ");
    put_str("L'a' "); put_str("u8\"\\x41\\u00e9\\U0001F600\\101\" ");
    put_str("U\"\\x\" "); put_str("u\"\\u12\" "); put_str("\"\\U1234\" ");
    put_str("'\\q' "); put_str("\"abc");
    pending_bytes.push_back('{ch: 8'h00, first: 1'b0});
    put_str("R\"ab(x)a)ab\" "); put_str("LR\"abcdefghijklmnopq(");
    put_str("uR\"a b(\"\" "); put_str("UR\"(x;");
    pending_bytes.push_back('{ch: 8'h00, first: 1'b0});
    put_str("@"); pending_bytes.push_back('{ch: 8'h00, first: 1'b1});
    // idle continuation and a restart mid-token
    pending_bytes.push_back('{ch: 8'hFF, first: 1'b0});
    put_str("\"unfinished"); put_str("x ");
    // random part; raw byte noise drives random values in both fields
    for (int i = 0; i < 25; i++) begin
      if ($urandom_range(15) == 0)
        pending_bytes.push_back('{ch: 8'($urandom_range(255)), first: 1'($urandom_range(1))});
      else put_str(rand_token());
      if (i == 12) pending_bytes.push_back('{ch: "a", first: 1'b1});
    end
    total_n = pending_bytes.size();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    // hold the output once while input keeps flowing
    while (pending_bytes.size() > total_n / 2) @(posedge clk_i);
    stall_req <= 1'b1;
    @(posedge clk_i);
    stall_req <= 1'b0;
    while ((pending_bytes.size() != 0 || s_tvalid || expected_tokens.size() != 0)
           && cycles < LIMIT_CYCLES) @(posedge clk_i);
    if (cycles >= LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      repeat (20) @(posedge clk_i);
      if (mismatches == 0 && expected_tokens.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
